// File: sv/assert_macros.svh
// Assertion macros used by the top level of the normalized window convolution block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies another in the same cycle.
`define NWC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies another in the next cycle.
`define NWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/nwc_pkg.sv
// Package with the types, codes and constants of the normalized window convolution block.
`timescale 1ns / 1ps
`default_nettype none

package nwc_pkg;

    localparam int DATA_W      = 16;
    localparam int PROD_W      = 32;
    localparam int COEF_STRIDE = 7;
    localparam int COEF_DEPTH  = 49;
    localparam int COEF_AW     = 6;
    localparam int CI_W        = 8;
    localparam int ACC_W       = 39;
    localparam int WS_W        = 22;
    localparam int CFG_W       = 11;
    localparam int RAD_W       = 2;
    localparam int TAP_W       = 3;
    localparam int CNT_W       = 6;
    localparam int POS_W       = 15;
    localparam int OUT_POS_W   = 10;
    localparam int DRAIN_LAST  = 2;

    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_MAX_HEIGHT   = 1024;
    localparam int DEF_MAX_RADIUS_X = 3;
    localparam int DEF_MAX_RADIUS_Y = 3;

    localparam logic [CFG_W-1:0] RST_WIDTH  = 11'd64;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd64;
    localparam logic [RAD_W-1:0] RST_RX     = 2'd1;
    localparam logic [RAD_W-1:0] RST_RY     = 2'd1;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RX     = 2'd2;
    localparam logic [1:0] REG_RY     = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAP,
        ST_DRAIN,
        ST_DIV,
        ST_OUT,
        ST_ERR_OUT
    } state_t;

    typedef struct packed {
        logic             coef_wr;
        logic             pix_wr;
        logic             tap_clear;
        logic             tap_issue;
        logic [TAP_W-1:0] tap_ky;
        logic [TAP_W-1:0] tap_kx;
        logic             div_load;
        logic             div_step;
        logic             out_res;
        logic             out_err;
    } cmd_t;

    typedef struct packed {
        logic cfg_bad;
        logic recv_done;
        logic past_delay;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// File: sv/nwc_ram.sv
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module nwc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 49
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/nwc_ctrl.sv
// Controller state machine that sequences item decode, window taps, division and output.
`timescale 1ns / 1ps
`default_nettype none

module nwc_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic [1:0]               operation,
    input  wire logic [nwc_pkg::RAD_W-1:0] kernel_radius_x,
    input  wire logic [nwc_pkg::RAD_W-1:0] kernel_radius_y,
    input  wire nwc_pkg::status_t         status,
    output nwc_pkg::cmd_t                 cmd,
    output logic                          in_stall
);

    nwc_pkg::state_t                state_reg, state_next;
    logic [nwc_pkg::TAP_W-1:0]      ky_reg, ky_next;
    logic [nwc_pkg::TAP_W-1:0]      kx_reg, kx_next;
    logic [nwc_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [nwc_pkg::TAP_W-1:0]      kx_last;
    logic [nwc_pkg::TAP_W-1:0]      ky_last;

    assign kx_last = {kernel_radius_x, 1'b0};
    assign ky_last = {kernel_radius_y, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nwc_pkg::ST_IDLE;
            ky_reg    <= '0;
            kx_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ky_reg    <= ky_next;
            kx_reg    <= kx_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ky_next    = ky_reg;
        kx_next    = kx_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            nwc_pkg::ST_IDLE:
            begin
                ky_next = '0;
                kx_next = '0;
                if (in_valid)
                begin
                    if (operation == nwc_pkg::OP_PIXEL)
                    begin
                        if (status.cfg_bad)
                        begin
                            state_next = nwc_pkg::ST_ERR_OUT;
                        end
                        else if (!status.recv_done && status.past_delay)
                        begin
                            state_next = nwc_pkg::ST_TAP;
                        end
                    end
                    else if (operation == nwc_pkg::OP_FLUSH)
                    begin
                        if (!status.cfg_bad && status.recv_done)
                        begin
                            state_next = nwc_pkg::ST_TAP;
                        end
                    end
                end
            end
            nwc_pkg::ST_TAP:
            begin
                if (kx_reg == kx_last)
                begin
                    kx_next = '0;
                    ky_next = ky_reg + 1'b1;
                    if (ky_reg == ky_last)
                    begin
                        state_next = nwc_pkg::ST_DRAIN;
                        cnt_next   = '0;
                    end
                end
                else
                begin
                    kx_next = kx_reg + 1'b1;
                end
            end
            nwc_pkg::ST_DRAIN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == nwc_pkg::CNT_W'(nwc_pkg::DRAIN_LAST))
                begin
                    state_next = nwc_pkg::ST_DIV;
                    cnt_next   = '0;
                end
            end
            nwc_pkg::ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == nwc_pkg::CNT_W'(nwc_pkg::ACC_W - 1))
                begin
                    state_next = nwc_pkg::ST_OUT;
                end
            end
            nwc_pkg::ST_OUT, nwc_pkg::ST_ERR_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = nwc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nwc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        cmd.tap_ky = ky_reg;
        cmd.tap_kx = kx_reg;
        case (state_reg)
            nwc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (operation == nwc_pkg::OP_LOAD)
                    begin
                        cmd.coef_wr = 1'b1;
                    end
                    else if (operation == nwc_pkg::OP_PIXEL)
                    begin
                        if (!status.cfg_bad && !status.recv_done)
                        begin
                            cmd.pix_wr    = 1'b1;
                            cmd.tap_clear = status.past_delay;
                        end
                    end
                    else if (operation == nwc_pkg::OP_FLUSH)
                    begin
                        cmd.tap_clear = !status.cfg_bad && status.recv_done;
                    end
                end
            end
            nwc_pkg::ST_TAP:
            begin
                cmd.tap_issue = 1'b1;
            end
            nwc_pkg::ST_DRAIN:
            begin
                cmd.div_load = (cnt_reg == nwc_pkg::CNT_W'(nwc_pkg::DRAIN_LAST));
            end
            nwc_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            nwc_pkg::ST_OUT:
            begin
                cmd.out_res = status.out_free;
            end
            nwc_pkg::ST_ERR_OUT:
            begin
                cmd.out_err = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/nwc_dp.sv
// Datapath with the frame counters, both stores, the multiply-accumulate, the divider and the output register.
`timescale 1ns / 1ps
`default_nettype none

module nwc_dp #(
    parameter int MAX_WIDTH    = nwc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = nwc_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS_X = nwc_pkg::DEF_MAX_RADIUS_X,
    parameter int MAX_RADIUS_Y = nwc_pkg::DEF_MAX_RADIUS_Y
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [nwc_pkg::CFG_W-1:0]        image_width,
    input  wire logic [nwc_pkg::CFG_W-1:0]        image_height,
    input  wire logic [nwc_pkg::RAD_W-1:0]        kernel_radius_x,
    input  wire logic [nwc_pkg::RAD_W-1:0]        kernel_radius_y,
    input  wire logic                             cfg_clear,
    input  wire logic [5:0]                       coefficient_index,
    input  wire logic signed [nwc_pkg::DATA_W-1:0] sample_value,
    input  wire nwc_pkg::cmd_t                    cmd,
    output nwc_pkg::status_t                      status,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic signed [nwc_pkg::DATA_W-1:0]     filtered_value,
    output logic [nwc_pkg::OUT_POS_W-1:0]         pixel_column,
    output logic [nwc_pkg::OUT_POS_W-1:0]         pixel_row,
    output logic                                  frame_last,
    output logic                                  zero_weight,
    output logic                                  config_error
);

    localparam int LINE_ROWS  = 2 * MAX_RADIUS_Y + 1;
    localparam int SLOT_W     = $clog2(LINE_ROWS);
    localparam int LINE_DEPTH = LINE_ROWS * MAX_WIDTH;
    localparam int LA_W       = $clog2(LINE_DEPTH);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
    localparam int TW         = $clog2(3 * LINE_ROWS + 8);
    localparam int DW         = nwc_pkg::DATA_W;
    localparam int PW         = nwc_pkg::POS_W;

    logic [COL_W-1:0]  rcol_reg, rcol_next, ecol_reg, ecol_next;
    logic [ROW_W-1:0]  rrow_reg, rrow_next, erow_reg, erow_next;
    logic [SLOT_W-1:0] rslot_reg, rslot_next, eslot_reg, eslot_next;

    logic [PW-1:0] w_p, h_p, rx_p, ry_p, rcol_p, rrow_p, ecol_p, erow_p, ky_p, kx_p;
    logic [PW-1:0] iy_p, ix_p;
    logic          cfg_bad, tap_ok, ci_ok, e_last_col, e_last;
    logic [nwc_pkg::CI_W-1:0] ci_w;
    logic [TW-1:0] slot_t;
    logic [SLOT_W-1:0] tap_slot;
    logic [LA_W-1:0]   line_waddr, line_raddr;
    logic signed [DW-1:0] line_rdata, coef_rdata;
    logic          coef_we;

    logic                                v1_reg, v2_reg;
    logic signed [nwc_pkg::PROD_W-1:0]   prod_reg;
    logic signed [DW-1:0]                coefp_reg;
    logic signed [nwc_pkg::ACC_W-1:0]    acc_reg;
    logic signed [nwc_pkg::WS_W-1:0]     wsum_reg;

    logic [nwc_pkg::ACC_W-1:0] dvd_reg, acc_mag;
    logic [nwc_pkg::WS_W:0]    rem_reg, rem_sh;
    logic [nwc_pkg::WS_W-1:0]  dvs_reg, ws_mag;
    logic                      neg_reg, zw_reg;
    logic signed [DW-1:0]      sat_value;

    logic                 out_valid_reg;
    logic signed [DW-1:0] val_reg;
    logic [nwc_pkg::OUT_POS_W-1:0] col_reg, row_reg;
    logic                 last_reg, zero_reg, err_reg;

    assign w_p    = PW'(image_width);
    assign h_p    = PW'(image_height);
    assign rx_p   = PW'(kernel_radius_x);
    assign ry_p   = PW'(kernel_radius_y);
    assign rcol_p = PW'(rcol_reg);
    assign rrow_p = PW'(rrow_reg);
    assign ecol_p = PW'(ecol_reg);
    assign erow_p = PW'(erow_reg);
    assign ky_p   = PW'(cmd.tap_ky);
    assign kx_p   = PW'(cmd.tap_kx);

    assign cfg_bad = (w_p < PW'(2)) || (h_p < PW'(2))
                  || (w_p > PW'(MAX_WIDTH)) || (h_p > PW'(MAX_HEIGHT))
                  || (rx_p > PW'(MAX_RADIUS_X)) || (ry_p > PW'(MAX_RADIUS_Y))
                  || ((rx_p << 1) + PW'(1) >= w_p) || ((ry_p << 1) + PW'(1) >= h_p);

    assign status.cfg_bad    = cfg_bad;
    assign status.recv_done  = (rrow_p == h_p);
    assign status.past_delay = (rrow_p > ry_p) || ((rrow_p == ry_p) && (rcol_p >= rx_p));
    assign status.out_free   = !out_valid_reg || !out_stall;

    // Row wrapped below zero reads as a huge unsigned value, so one compare clips both ends.
    assign iy_p   = erow_p - ry_p + ky_p;
    assign ix_p   = ecol_p - rx_p + kx_p;
    assign ci_w   = nwc_pkg::CI_W'(cmd.tap_ky) * nwc_pkg::CI_W'(nwc_pkg::COEF_STRIDE)
                  + nwc_pkg::CI_W'(cmd.tap_kx);
    assign ci_ok  = ci_w < nwc_pkg::CI_W'(nwc_pkg::COEF_DEPTH);
    assign tap_ok = (iy_p < h_p) && (ix_p < w_p) && ci_ok;

    always_comb
    begin
        slot_t = TW'(eslot_reg) + TW'(LINE_ROWS) + TW'(cmd.tap_ky) - TW'(kernel_radius_y);
        if (slot_t >= TW'(2 * LINE_ROWS))
        begin
            slot_t = slot_t - TW'(2 * LINE_ROWS);
        end
        else if (slot_t >= TW'(LINE_ROWS))
        begin
            slot_t = slot_t - TW'(LINE_ROWS);
        end
        tap_slot = slot_t[SLOT_W-1:0];
    end

    assign line_waddr = LA_W'(rslot_reg) * LA_W'(MAX_WIDTH) + LA_W'(rcol_reg);
    assign line_raddr = LA_W'(tap_slot) * LA_W'(MAX_WIDTH) + ix_p[LA_W-1:0];
    assign coef_we    = cmd.coef_wr && (coefficient_index < 6'(nwc_pkg::COEF_DEPTH));

    nwc_ram #(
        .WIDTH(DW),
        .DEPTH(nwc_pkg::COEF_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coefficient_index[nwc_pkg::COEF_AW-1:0]),
        .wdata (sample_value),
        .raddr (ci_w[nwc_pkg::COEF_AW-1:0]),
        .rdata (coef_rdata)
    );

    nwc_ram #(
        .WIDTH(DW),
        .DEPTH(LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (cmd.pix_wr),
        .waddr (line_waddr),
        .wdata (sample_value),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    assign e_last_col = (ecol_p == w_p - PW'(1));
    assign e_last     = e_last_col && (erow_p == h_p - PW'(1));

    always_comb
    begin
        rcol_next  = rcol_reg;
        rrow_next  = rrow_reg;
        rslot_next = rslot_reg;
        ecol_next  = ecol_reg;
        erow_next  = erow_reg;
        eslot_next = eslot_reg;
        if (cmd.pix_wr)
        begin
            if (rcol_p == w_p - PW'(1))
            begin
                rcol_next  = '0;
                rrow_next  = rrow_reg + 1'b1;
                rslot_next = (rslot_reg == SLOT_W'(LINE_ROWS - 1)) ? '0 : rslot_reg + 1'b1;
            end
            else
            begin
                rcol_next = rcol_reg + 1'b1;
            end
        end
        if (cmd.out_res)
        begin
            if (e_last)
            begin
                ecol_next  = '0;
                erow_next  = '0;
                eslot_next = '0;
                rcol_next  = '0;
                rrow_next  = '0;
                rslot_next = '0;
            end
            else if (e_last_col)
            begin
                ecol_next  = '0;
                erow_next  = erow_reg + 1'b1;
                eslot_next = (eslot_reg == SLOT_W'(LINE_ROWS - 1)) ? '0 : eslot_reg + 1'b1;
            end
            else
            begin
                ecol_next = ecol_reg + 1'b1;
            end
        end
        if (cfg_clear)
        begin
            ecol_next  = '0;
            erow_next  = '0;
            eslot_next = '0;
            rcol_next  = '0;
            rrow_next  = '0;
            rslot_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcol_reg      <= '0;
            rrow_reg      <= '0;
            rslot_reg     <= '0;
            ecol_reg      <= '0;
            erow_reg      <= '0;
            eslot_reg     <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rcol_reg  <= rcol_next;
            rrow_reg  <= rrow_next;
            rslot_reg <= rslot_next;
            ecol_reg  <= ecol_next;
            erow_reg  <= erow_next;
            eslot_reg <= eslot_next;
            v1_reg    <= cmd.tap_issue && tap_ok;
            v2_reg    <= v1_reg;
            if (cmd.out_res || cmd.out_err)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign acc_mag = acc_reg[nwc_pkg::ACC_W-1] ? nwc_pkg::ACC_W'(-acc_reg) : nwc_pkg::ACC_W'(acc_reg);
    assign ws_mag  = wsum_reg[nwc_pkg::WS_W-1] ? nwc_pkg::WS_W'(-wsum_reg) : nwc_pkg::WS_W'(wsum_reg);
    assign rem_sh  = {rem_reg[nwc_pkg::WS_W-1:0], dvd_reg[nwc_pkg::ACC_W-1]};

    always_comb
    begin
        if (neg_reg)
        begin
            if (dvd_reg > nwc_pkg::ACC_W'(32768))
            begin
                sat_value = 16'sh8000;
            end
            else
            begin
                sat_value = signed'(DW'(~dvd_reg + 1'b1));
            end
        end
        else
        begin
            if (dvd_reg > nwc_pkg::ACC_W'(32767))
            begin
                sat_value = 16'sh7fff;
            end
            else
            begin
                sat_value = signed'(dvd_reg[DW-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= line_rdata * coef_rdata;
        coefp_reg <= coef_rdata;
        if (cmd.tap_clear)
        begin
            acc_reg  <= '0;
            wsum_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg  <= acc_reg + nwc_pkg::ACC_W'(prod_reg);
            wsum_reg <= wsum_reg + nwc_pkg::WS_W'(coefp_reg);
        end
        if (cmd.div_load)
        begin
            dvd_reg <= acc_mag;
            dvs_reg <= ws_mag;
            rem_reg <= '0;
            neg_reg <= acc_reg[nwc_pkg::ACC_W-1] ^ wsum_reg[nwc_pkg::WS_W-1];
            zw_reg  <= (wsum_reg == '0);
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_reg <= rem_sh - {1'b0, dvs_reg};
                dvd_reg <= {dvd_reg[nwc_pkg::ACC_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                dvd_reg <= {dvd_reg[nwc_pkg::ACC_W-2:0], 1'b0};
            end
        end
        if (cmd.out_res)
        begin
            val_reg  <= zw_reg ? '0 : sat_value;
            col_reg  <= nwc_pkg::OUT_POS_W'(ecol_reg);
            row_reg  <= nwc_pkg::OUT_POS_W'(erow_reg);
            last_reg <= e_last;
            zero_reg <= zw_reg;
            err_reg  <= 1'b0;
        end
        else if (cmd.out_err)
        begin
            val_reg  <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
            last_reg <= 1'b0;
            zero_reg <= 1'b0;
            err_reg  <= 1'b1;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = val_reg;
    assign pixel_column   = col_reg;
    assign pixel_row      = row_reg;
    assign frame_last     = last_reg;
    assign zero_weight    = zero_reg;
    assign config_error   = err_reg;

endmodule

`default_nettype wire

// File: sv/normalized_window_convolution.sv
// Top level of the normalized window convolution block with its configuration registers.
//
//  channel   direction  handshake             payload
//  in        input      in_valid / in_stall   operation, coefficient_index, sample_value
//  out       output     out_valid / out_stall filtered_value, pixel_column, pixel_row, flags
//  config    input      APB psel / penable    paddr, pwdata, prdata
//
// A load or a pixel that causes no result does not leave the idle state. A result passes
// through each kernel tap in turn on the shared multiplier, then a drain of the multiply
// pipeline and the bit-serial divider, then the output register.
// Reset clears the counters and returns the configuration to its defaults; both stores
// hold nothing defined.
// Input stalls while an item is being worked on or its result waits for the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module normalized_window_convolution #(
    parameter int MAX_WIDTH    = nwc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = nwc_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS_X = nwc_pkg::DEF_MAX_RADIUS_X,
    parameter int MAX_RADIUS_Y = nwc_pkg::DEF_MAX_RADIUS_Y
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [3:0]                        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [1:0]                        operation,
    input  wire logic [5:0]                        coefficient_index,
    input  wire logic signed [nwc_pkg::DATA_W-1:0] sample_value,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [nwc_pkg::DATA_W-1:0]      filtered_value,
    output logic [nwc_pkg::OUT_POS_W-1:0]          pixel_column,
    output logic [nwc_pkg::OUT_POS_W-1:0]          pixel_row,
    output logic                                   frame_last,
    output logic                                   zero_weight,
    output logic                                   config_error
);

    logic [nwc_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [nwc_pkg::RAD_W-1:0] rx_reg, ry_reg;
    logic                      cfg_wr;
    nwc_pkg::cmd_t             cmd;
    nwc_pkg::status_t          status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= nwc_pkg::RST_WIDTH;
            height_reg <= nwc_pkg::RST_HEIGHT;
            rx_reg     <= nwc_pkg::RST_RX;
            ry_reg     <= nwc_pkg::RST_RY;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                nwc_pkg::REG_WIDTH:  width_reg  <= pwdata[nwc_pkg::CFG_W-1:0];
                nwc_pkg::REG_HEIGHT: height_reg <= pwdata[nwc_pkg::CFG_W-1:0];
                nwc_pkg::REG_RX:     rx_reg     <= pwdata[nwc_pkg::RAD_W-1:0];
                nwc_pkg::REG_RY:     ry_reg     <= pwdata[nwc_pkg::RAD_W-1:0];
                default:             width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            nwc_pkg::REG_WIDTH:  prdata = 32'(width_reg);
            nwc_pkg::REG_HEIGHT: prdata = 32'(height_reg);
            nwc_pkg::REG_RX:     prdata = 32'(rx_reg);
            nwc_pkg::REG_RY:     prdata = 32'(ry_reg);
            default:             prdata = '0;
        endcase
    end

    nwc_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .operation       (operation),
        .kernel_radius_x (rx_reg),
        .kernel_radius_y (ry_reg),
        .status          (status),
        .cmd             (cmd),
        .in_stall        (in_stall)
    );

    nwc_dp #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_RADIUS_X (MAX_RADIUS_X),
        .MAX_RADIUS_Y (MAX_RADIUS_Y)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .image_width       (width_reg),
        .image_height      (height_reg),
        .kernel_radius_x   (rx_reg),
        .kernel_radius_y   (ry_reg),
        .cfg_clear         (cfg_wr),
        .coefficient_index (coefficient_index),
        .sample_value      (sample_value),
        .cmd               (cmd),
        .status            (status),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .filtered_value    (filtered_value),
        .pixel_column      (pixel_column),
        .pixel_row         (pixel_row),
        .frame_last        (frame_last),
        .zero_weight       (zero_weight),
        .config_error      (config_error)
    );

    `NWC_ASSERT_IMPLY(a_err_clean, out_valid && config_error, filtered_value == 16'sd0 && zero_weight == 1'b0 && frame_last == 1'b0, "error item carries payload")
    `NWC_ASSERT_IMPLY(a_zero_value, out_valid && zero_weight, filtered_value == 16'sd0, "zero weight item with nonzero value")
    `NWC_ASSERT_IMPLY(a_last_col, out_valid && frame_last, 11'(pixel_column) == width_reg - 11'd1, "frame end not at last column")
    `NWC_ASSERT_NEXT(a_err_busy, in_valid && !in_stall && operation == nwc_pkg::OP_PIXEL && status.cfg_bad, in_stall, "error item did not stall input")

endmodule

`default_nettype wire
